// File: design/obpb_pkg.sv
// Shared types, codes and helpers for the oriented box plane builder.
// No dependencies; imported by obpb_mul, the top level and the bench.
package obpb_pkg;

    typedef logic signed [31:0] word_t;
    typedef logic signed [63:0] prod_t;

    localparam int FRAC_BITS_DEF = 16;

    // input slot codes
    localparam logic [2:0] SLOT_COL0  = 3'd0;
    localparam logic [2:0] SLOT_COL1  = 3'd1;
    localparam logic [2:0] SLOT_COL2  = 3'd2;
    localparam logic [2:0] SLOT_TRANS = 3'd3;
    localparam logic [2:0] SLOT_SIZE  = 3'd4;
    localparam logic [2:0] SLOT_OFFS  = 3'd5;
    // slots that store nothing
    localparam logic [2:0] SLOT_SPARE_A = 3'd6;
    localparam logic [2:0] SLOT_SPARE_B = 3'd7;

    // result index codes for the two bound words
    localparam logic [2:0] IDX_LO = 3'd6;
    localparam logic [2:0] IDX_HI = 3'd7;

    localparam prod_t S32_MAX = 64'sd2147483647;
    localparam prod_t S32_MIN = -64'sd2147483648;

    function automatic word_t sat32(input prod_t v);
        if (v > S32_MAX)
        begin
            return 32'sh7fffffff;
        end
        else if (v < S32_MIN)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [1:0] next3(input logic [1:0] j);
        return (j == 2'd2) ? 2'd0 : j + 2'd1;
    endfunction

    // corner triples that span each face: anchor, edge one, edge two
    function automatic logic [2:0] face_vtx(input logic [2:0] f, input logic [1:0] s);
        logic [8:0] row;
        case (f)
            3'd0:    row = {3'd0, 3'd3, 3'd4};
            3'd1:    row = {3'd1, 3'd5, 3'd2};
            3'd2:    row = {3'd3, 3'd7, 3'd2};
            3'd3:    row = {3'd0, 3'd1, 3'd4};
            3'd4:    row = {3'd0, 3'd1, 3'd3};
            3'd5:    row = {3'd4, 3'd7, 3'd5};
            default: row = 9'd0;
        endcase
        case (s)
            2'd0:    return row[8:6];
            2'd1:    return row[5:3];
            default: return row[2:0];
        endcase
    endfunction

    // corner used for the plane distance of each face
    function automatic logic [2:0] anchor_vtx(input logic [2:0] f);
        case (f)
            3'd1:    return 3'd1;
            3'd3:    return 3'd3;
            3'd5:    return 3'd4;
            default: return 3'd0;
        endcase
    endfunction

endpackage

// File: design/obpb_mul.sv
// Shared signed 32x32 multiplier with registered 64-bit product.
// Depends on obpb_pkg for word and product types.
module obpb_mul (
    input  logic           clk,
    input  obpb_pkg::word_t a,
    input  obpb_pkg::word_t b,
    output obpb_pkg::prod_t prod
);
    import obpb_pkg::*;

    prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
    end

    assign prod = prod_reg;

endmodule

// File: design/oriented_box_plane_builder.sv
// Top level: oriented box to six face planes plus an axis-aligned bound.
// Depends on obpb_pkg and obpb_mul (shared multiplier).
//
// Usage
//   Load words: drive slot/val_x/val_y/val_z/go with start high; a word is
//   taken at an edge where start is high and busy is low. Slots 0..2 are the
//   linear columns, 3 the translation, 4 the box size (kept halved), 5 the
//   center offset; slots 6 and 7 store nothing. A word with go clear only
//   stores.
//   A word with go set stores, then builds the box with busy high. Every
//   product goes through one shared multiplier (72 for the corners, 12
//   per face for cross, squares and dot); each face also runs a
//   one-bit-per-cycle shift normalizer, a 32-step integer square root and
//   three (FRAC_BITS+1)-step dividers. A degenerate face skips the
//   normalizer, squares, square root and divides.
//   Results: eight words, each on the result ports for one cycle under
//   result_strobe: planes 0..5, then bound minimum (6) and maximum (7) with
//   last_item. The receiver cannot stall; the words simply go out.
//   Config: cfg_data (particle radius) is written when cfg_valid is high;
//   cfg_ready is always high. Write it only while the block is idle.
//   Reset: all stored vectors and the radius clear to zero, block idle.
module oriented_box_plane_builder #(
    parameter int FRAC_BITS = obpb_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [2:0]      slot,
    input  obpb_pkg::word_t val_x,
    input  obpb_pkg::word_t val_y,
    input  obpb_pkg::word_t val_z,
    input  logic            go,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [30:0]     cfg_data,
    output logic            result_strobe,
    output logic [2:0]      item_index,
    output obpb_pkg::word_t comp_x,
    output obpb_pkg::word_t comp_y,
    output obpb_pkg::word_t comp_z,
    output obpb_pkg::word_t comp_w,
    output logic            last_item
);
    import obpb_pkg::*;

    localparam int IT_W = $clog2(FRAC_BITS + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CORN  = 4'd1;   // corners through linear part
    localparam logic [3:0] ST_LOAD  = 4'd2;   // edge vectors of one face
    localparam logic [3:0] ST_CROSS = 4'd3;
    localparam logic [3:0] ST_NORM  = 4'd4;   // scale max magnitude into [2^29,2^30)
    localparam logic [3:0] ST_SQSUM = 4'd5;
    localparam logic [3:0] ST_SQRT  = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_DOT   = 4'd8;   // distance, emits plane word
    localparam logic [3:0] ST_BOUND = 4'd9;
    localparam logic [3:0] ST_EMLO  = 4'd10;
    localparam logic [3:0] ST_EMHI  = 4'd11;

    localparam logic [63:0] NORM_HI = 64'd1 << 30;
    localparam logic [63:0] NORM_LO = 64'd1 << 29;

    // control
    logic [3:0] state_reg, state_next;
    logic [2:0] ca_reg, ca_next;     // corner k / face f
    logic [1:0] cb_reg, cb_next;     // component
    logic [1:0] cc_reg, cc_next;     // term / vertex select
    logic       ph_reg, ph_next;     // multiplier phase: issue, collect

    // box description and config
    word_t       lin_reg   [0:8];
    word_t       lin_next  [0:8];
    word_t       trans_reg [0:2];
    word_t       trans_next[0:2];
    word_t       half_reg  [0:2];
    word_t       half_next [0:2];
    word_t       cofs_reg  [0:2];
    word_t       cofs_next [0:2];
    logic [30:0] radius_reg, radius_next;

    // working storage
    word_t         corner_reg [0:23];
    word_t         corner_next[0:23];
    word_t         base_reg[0:2], base_next[0:2];
    word_t         d1_reg[0:2], d1_next[0:2];
    word_t         d2_reg[0:2], d2_next[0:2];
    word_t         nrm_reg[0:2], nrm_next[0:2];
    logic [63:0]   mag_reg[0:2], mag_next[0:2];
    logic [2:0]    neg_reg, neg_next;
    logic [63:0]   max_reg, max_next;
    prod_t         acc_reg, acc_next;
    logic [63:0]   sqx_reg, sqx_next;
    logic [63:0]   rt_reg, rt_next;
    logic [63:0]   bit_reg, bit_next;
    logic [31:0]   len_reg, len_next;
    logic [32:0]   rem_reg, rem_next;
    logic [FRAC_BITS:0] q_reg, q_next;
    logic [IT_W-1:0]    it_reg, it_next;
    logic signed [33:0] lo_reg[0:2], lo_next[0:2];
    logic signed [33:0] hi_reg[0:2], hi_next[0:2];

    // result word
    logic       strobe_reg, strobe_next;
    logic [2:0] idx_reg, idx_next;
    word_t      ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next, ow_reg, ow_next;
    logic       last_reg, last_next;

    // shared datapath
    word_t       mul_a, mul_b;
    prod_t       prod, fm, term;
    logic [2:0]  vtx;
    logic [4:0]  cs_addr;
    word_t       cs_rd;
    logic [3:0]  lin_idx;
    logic        pneg;
    prod_t       hs;
    word_t       pj;
    logic [1:0]  j1, j2;
    prod_t       sum, crv;
    logic [63:0] cabs, newmax, trial;
    logic [32:0] cur, lenx;
    logic        ge;
    logic [FRAC_BITS:0] qn;
    word_t       qw, diff, pb;
    logic signed [33:0] bnd_lo, bnd_hi, rad34;

    obpb_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign fm = prod >>> FRAC_BITS;   // floored fixed-point product

    // single read port into the corner store
    always_comb
    begin
        if (state_reg == ST_LOAD)
        begin
            vtx = face_vtx(ca_reg, cc_reg);
        end
        else if (state_reg == ST_DOT)
        begin
            vtx = anchor_vtx(ca_reg);
        end
        else
        begin
            vtx = ca_reg;
        end
    end
    assign cs_addr = 5'({vtx, 1'b0}) + 5'(vtx) + 5'(cb_reg);
    assign cs_rd   = corner_reg[cs_addr];

    // corner component before the linear part: +-half + offset by corner number
    always_comb
    begin
        case (cc_reg)
            2'd0:    pneg = ca_reg[0] ^ ca_reg[1];
            2'd1:    pneg = ca_reg[1];
            default: pneg = ca_reg[2];
        endcase
    end
    assign hs      = pneg ? -64'(half_reg[cc_reg]) : 64'(half_reg[cc_reg]);
    assign pj      = sat32(hs + 64'(cofs_reg[cc_reg]));
    assign lin_idx = 4'({cc_reg, 1'b0}) + 4'(cc_reg) + 4'(cb_reg);
    assign j1      = next3(cb_reg);
    assign j2      = next3(j1);

    always_comb
    begin
        case (state_reg)
            ST_CORN:
            begin
                mul_a = lin_reg[lin_idx];
                mul_b = pj;
            end
            ST_CROSS:
            begin
                mul_a = cc_reg[0] ? d1_reg[j2] : d1_reg[j1];
                mul_b = cc_reg[0] ? d2_reg[j1] : d2_reg[j2];
            end
            ST_SQSUM:
            begin
                mul_a = 32'(mag_reg[cb_reg][29:0]);
                mul_b = 32'(mag_reg[cb_reg][29:0]);
            end
            ST_DOT:
            begin
                mul_a = cs_rd;
                mul_b = nrm_reg[cb_reg];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // small helpers shared by several states; squares are integer, not fixed point
    assign term   = (state_reg == ST_SQSUM) ? prod : fm;
    assign sum    = ((cb_reg == 2'd0 && state_reg != ST_CORN) ||
                     (cc_reg == 2'd0 && state_reg == ST_CORN)) ? term
                    : acc_reg + term;
    assign crv    = acc_reg - fm;
    assign cabs   = crv[63] ? 64'(-crv) : 64'(crv);
    assign newmax = (cabs > max_reg) ? cabs : max_reg;
    assign trial  = rt_reg + bit_reg;
    assign cur    = (it_reg == '0) ? 33'(mag_reg[cb_reg][29:0]) : {rem_reg[31:0], 1'b0};
    assign lenx   = {1'b0, len_reg};
    assign ge     = cur >= lenx;
    assign qn     = (it_reg == '0) ? (FRAC_BITS + 1)'(ge) : {q_reg[FRAC_BITS-1:0], ge};
    assign qw     = 32'(qn);
    assign diff   = sat32(64'(cs_rd) - 64'(base_reg[cb_reg]));
    assign pb     = sat32(64'(cs_rd) + 64'(trans_reg[cb_reg]));
    assign rad34  = $signed({3'b000, radius_reg});
    assign bnd_lo = 34'(pb) - rad34;
    assign bnd_hi = 34'(pb) + rad34;

    always_comb
    begin
        state_next  = state_reg;
        ca_next     = ca_reg;
        cb_next     = cb_reg;
        cc_next     = cc_reg;
        ph_next     = ph_reg;
        lin_next    = lin_reg;
        trans_next  = trans_reg;
        half_next   = half_reg;
        cofs_next   = cofs_reg;
        radius_next = radius_reg;
        corner_next = corner_reg;
        base_next   = base_reg;
        d1_next     = d1_reg;
        d2_next     = d2_reg;
        nrm_next    = nrm_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        max_next    = max_reg;
        acc_next    = acc_reg;
        sqx_next    = sqx_reg;
        rt_next     = rt_reg;
        bit_next    = bit_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        it_next     = it_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        strobe_next = 1'b0;
        idx_next    = idx_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oz_next     = oz_reg;
        ow_next     = ow_reg;
        last_next   = last_reg;

        if (cfg_valid)
        begin
            radius_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (slot inside {[SLOT_COL0:SLOT_COL2]})
                    begin
                        lin_next[4'({slot[1:0], 1'b0}) + 4'(slot[1:0])]        = val_x;
                        lin_next[4'({slot[1:0], 1'b0}) + 4'(slot[1:0]) + 4'd1] = val_y;
                        lin_next[4'({slot[1:0], 1'b0}) + 4'(slot[1:0]) + 4'd2] = val_z;
                    end
                    else if (slot == SLOT_TRANS)
                    begin
                        trans_next[0] = val_x;
                        trans_next[1] = val_y;
                        trans_next[2] = val_z;
                    end
                    else if (slot == SLOT_SIZE)
                    begin
                        half_next[0] = val_x >>> 1;
                        half_next[1] = val_y >>> 1;
                        half_next[2] = val_z >>> 1;
                    end
                    else if (slot == SLOT_OFFS)
                    begin
                        cofs_next[0] = val_x;
                        cofs_next[1] = val_y;
                        cofs_next[2] = val_z;
                    end
                    if (go)
                    begin
                        state_next = ST_CORN;
                        ca_next    = '0;
                        cb_next    = '0;
                        cc_next    = '0;
                        ph_next    = 1'b0;
                    end
                end
            end

            ST_CORN:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    if (cc_reg == 2'd2)
                    begin
                        corner_next[cs_addr] = sat32(sum);
                        cc_next = '0;
                        if (cb_reg == 2'd2)
                        begin
                            cb_next = '0;
                            if (ca_reg == 3'd7)
                            begin
                                state_next = ST_LOAD;
                                ca_next    = '0;
                            end
                            else
                            begin
                                ca_next = ca_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            cb_next = cb_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        acc_next = sum;
                        cc_next  = cc_reg + 2'd1;
                    end
                end
            end

            ST_LOAD:
            begin
                case (cc_reg)
                    2'd0:    base_next[cb_reg] = cs_rd;
                    2'd1:    d1_next[cb_reg]   = diff;
                    default: d2_next[cb_reg]   = diff;
                endcase
                if (cb_reg == 2'd2)
                begin
                    cb_next = '0;
                    if (cc_reg == 2'd2)
                    begin
                        state_next = ST_CROSS;
                        cc_next    = '0;
                        ph_next    = 1'b0;
                        max_next   = '0;
                    end
                    else
                    begin
                        cc_next = cc_reg + 2'd1;
                    end
                end
                else
                begin
                    cb_next = cb_reg + 2'd1;
                end
            end

            ST_CROSS:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    if (cc_reg == 2'd0)
                    begin
                        acc_next = fm;
                        cc_next  = 2'd1;
                    end
                    else
                    begin
                        cc_next          = '0;
                        neg_next[cb_reg] = crv[63];
                        mag_next[cb_reg] = cabs;
                        max_next         = newmax;
                        if (cb_reg == 2'd2)
                        begin
                            cb_next = '0;
                            if (newmax == '0)
                            begin
                                // degenerate face: zero normal
                                nrm_next[0] = '0;
                                nrm_next[1] = '0;
                                nrm_next[2] = '0;
                                state_next  = ST_DOT;
                            end
                            else
                            begin
                                state_next = ST_NORM;
                            end
                        end
                        else
                        begin
                            cb_next = cb_reg + 2'd1;
                        end
                    end
                end
            end

            ST_NORM:
            begin
                if (max_reg >= NORM_HI)
                begin
                    max_next    = max_reg >> 1;
                    mag_next[0] = mag_reg[0] >> 1;
                    mag_next[1] = mag_reg[1] >> 1;
                    mag_next[2] = mag_reg[2] >> 1;
                end
                else if (max_reg < NORM_LO)
                begin
                    max_next    = max_reg << 1;
                    mag_next[0] = mag_reg[0] << 1;
                    mag_next[1] = mag_reg[1] << 1;
                    mag_next[2] = mag_reg[2] << 1;
                end
                else
                begin
                    state_next = ST_SQSUM;
                    cb_next    = '0;
                    ph_next    = 1'b0;
                end
            end

            ST_SQSUM:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    if (cb_reg == 2'd2)
                    begin
                        sqx_next   = 64'(sum);
                        rt_next    = '0;
                        bit_next   = 64'd1 << 62;
                        state_next = ST_SQRT;
                    end
                    else
                    begin
                        acc_next = sum;
                        cb_next  = cb_reg + 2'd1;
                    end
                end
            end

            ST_SQRT:
            begin
                // one result bit per cycle
                if (sqx_reg >= trial)
                begin
                    sqx_next = sqx_reg - trial;
                    rt_next  = (rt_reg >> 1) + bit_reg;
                end
                else
                begin
                    rt_next = rt_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    len_next   = rt_next[31:0];
                    state_next = ST_DIV;
                    cb_next    = '0;
                    it_next    = '0;
                end
            end

            ST_DIV:
            begin
                // restoring divide of mag << FRAC_BITS by len, one bit per cycle
                rem_next = ge ? (cur - lenx) : cur;
                q_next   = qn;
                if (it_reg == IT_W'(FRAC_BITS))
                begin
                    nrm_next[cb_reg] = neg_reg[cb_reg] ? -qw : qw;
                    it_next          = '0;
                    if (cb_reg == 2'd2)
                    begin
                        state_next = ST_DOT;
                        cb_next    = '0;
                        ph_next    = 1'b0;
                    end
                    else
                    begin
                        cb_next = cb_reg + 2'd1;
                    end
                end
                else
                begin
                    it_next = it_reg + IT_W'(1);
                end
            end

            ST_DOT:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    if (cb_reg == 2'd2)
                    begin
                        strobe_next = 1'b1;
                        idx_next    = ca_reg;
                        ox_next     = nrm_reg[0];
                        oy_next     = nrm_reg[1];
                        oz_next     = nrm_reg[2];
                        ow_next     = sat32(-(sum + 64'(radius_reg)));
                        last_next   = 1'b0;
                        cb_next     = '0;
                        cc_next     = '0;
                        if (ca_reg == 3'd5)
                        begin
                            state_next = ST_BOUND;
                            ca_next    = '0;
                        end
                        else
                        begin
                            state_next = ST_LOAD;
                            ca_next    = ca_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        acc_next = sum;
                        cb_next  = cb_reg + 2'd1;
                    end
                end
            end

            ST_BOUND:
            begin
                if (ca_reg == 3'd0 || bnd_lo < lo_reg[cb_reg])
                begin
                    lo_next[cb_reg] = bnd_lo;
                end
                if (ca_reg == 3'd0 || bnd_hi > hi_reg[cb_reg])
                begin
                    hi_next[cb_reg] = bnd_hi;
                end
                if (cb_reg == 2'd2)
                begin
                    cb_next = '0;
                    if (ca_reg == 3'd7)
                    begin
                        state_next = ST_EMLO;
                    end
                    else
                    begin
                        ca_next = ca_reg + 3'd1;
                    end
                end
                else
                begin
                    cb_next = cb_reg + 2'd1;
                end
            end

            ST_EMLO:
            begin
                strobe_next = 1'b1;
                idx_next    = IDX_LO;
                ox_next     = sat32(64'(lo_reg[0]));
                oy_next     = sat32(64'(lo_reg[1]));
                oz_next     = sat32(64'(lo_reg[2]));
                ow_next     = '0;
                last_next   = 1'b0;
                state_next  = ST_EMHI;
            end

            ST_EMHI:
            begin
                strobe_next = 1'b1;
                idx_next    = IDX_HI;
                ox_next     = sat32(64'(hi_reg[0]));
                oy_next     = sat32(64'(hi_reg[1]));
                oz_next     = sat32(64'(hi_reg[2]));
                ow_next     = '0;
                last_next   = 1'b1;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ca_reg     <= '0;
            cb_reg     <= '0;
            cc_reg     <= '0;
            ph_reg     <= 1'b0;
            strobe_reg <= 1'b0;
            radius_reg <= '0;
            for (int i = 0; i < 9; i++)
            begin
                lin_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                trans_reg[i] <= '0;
                half_reg[i]  <= '0;
                cofs_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            ca_reg     <= ca_next;
            cb_reg     <= cb_next;
            cc_reg     <= cc_next;
            ph_reg     <= ph_next;
            strobe_reg <= strobe_next;
            radius_reg <= radius_next;
            lin_reg    <= lin_next;
            trans_reg  <= trans_next;
            half_reg   <= half_next;
            cofs_reg   <= cofs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        corner_reg <= corner_next;
        base_reg   <= base_next;
        d1_reg     <= d1_next;
        d2_reg     <= d2_next;
        nrm_reg    <= nrm_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        max_reg    <= max_next;
        acc_reg    <= acc_next;
        sqx_reg    <= sqx_next;
        rt_reg     <= rt_next;
        bit_reg    <= bit_next;
        len_reg    <= len_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        it_reg     <= it_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        oz_reg     <= oz_next;
        ow_reg     <= ow_next;
        last_reg   <= last_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_strobe = strobe_reg;
    assign item_index    = idx_reg;
    assign comp_x        = ox_reg;
    assign comp_y        = oy_reg;
    assign comp_z        = oz_reg;
    assign comp_w        = ow_reg;
    assign last_item     = last_reg;

`ifndef SYNTHESIS
    // final word of a run appears as the block returns to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_item) |-> !busy)
        else $error("last result word while still busy");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (last_item == (item_index == IDX_HI)))
        else $error("last_item out of step with item_index");

    // a load word without go never starts a build
    a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !go) |=> (!busy && !result_strobe))
        else $error("load word without go started a build");
`endif

endmodule

// File: bench/obpb_checker.sv
// Checker for the oriented box plane builder: predicts the eight result words of
// each box and compares every strobed word field by field, in order.
// Depends on obpb_pkg (word_t); watches the block's ports only.
module obpb_checker #(
    parameter int FRAC_BITS = obpb_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic [2:0]      slot,
    input  obpb_pkg::word_t val_x,
    input  obpb_pkg::word_t val_y,
    input  obpb_pkg::word_t val_z,
    input  logic            go,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [30:0]     cfg_data,
    input  logic            result_strobe,
    input  logic [2:0]      item_index,
    input  obpb_pkg::word_t comp_x,
    input  obpb_pkg::word_t comp_y,
    input  obpb_pkg::word_t comp_z,
    input  obpb_pkg::word_t comp_w,
    input  logic            last_item,
    output int              errors,
    output int              pending
);
    import obpb_pkg::*;

    typedef struct packed {
        logic [2:0] idx;
        word_t      x;
        word_t      y;
        word_t      z;
        word_t      w;
        logic       last;
    } box_word_t;

    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    // face corner triples (anchor, edge one, edge two) and plane anchor corners
    localparam int FACE_A[6] = '{0, 1, 3, 0, 0, 4};
    localparam int FACE_B[6] = '{3, 5, 7, 1, 1, 7};
    localparam int FACE_C[6] = '{4, 2, 2, 4, 3, 5};
    localparam int PLANE_PT[6] = '{0, 1, 0, 3, 0, 4};

    box_word_t plane_q[$];

    longint lin[9];
    longint trans[3];
    longint half_ext[3];
    longint offs[3];
    longint corner[24];
    longint nrm[18];
    longint radius;

    function automatic longint clamp32(input longint v);
        if (v > MAX32)
        begin
            return MAX32;
        end
        if (v < MIN32)
        begin
            return MIN32;
        end
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // unit normal of the cross product of two corner differences
    task automatic face_normal(input int f);
        longint d1[3];
        longint d2[3];
        longint cr[3];
        longint unsigned mag[3];
        longint unsigned m;
        longint unsigned len;
        longint q;
        bit neg[3];
        for (int i = 0; i < 3; i++)
        begin
            d1[i] = clamp32(corner[3*FACE_B[f]+i] - corner[3*FACE_A[f]+i]);
            d2[i] = clamp32(corner[3*FACE_C[f]+i] - corner[3*FACE_A[f]+i]);
        end
        cr[0] = qmul(d1[1], d2[2]) - qmul(d1[2], d2[1]);
        cr[1] = qmul(d1[2], d2[0]) - qmul(d1[0], d2[2]);
        cr[2] = qmul(d1[0], d2[1]) - qmul(d1[1], d2[0]);
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = cr[i] < 0;
            mag[i] = neg[i] ? -cr[i] : cr[i];
            if (mag[i] > m)
            begin
                m = mag[i];
            end
        end
        if (m == 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nrm[3*f+i] = 0;
            end
            return;
        end
        while (m >= (64'd1 << 30))
        begin
            m = m >> 1;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = mag[i] >> 1;
            end
        end
        while (m < (64'd1 << 29))
        begin
            m = m << 1;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = mag[i] << 1;
            end
        end
        len = root64(mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2]);
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] << FRAC_BITS) / len;
            nrm[3*f+i] = neg[i] ? -q : q;
        end
    endtask

    task automatic build_box();
        longint p[3];
        longint dot;
        longint t;
        longint lo[3];
        longint hi[3];
        box_word_t e;
        bit sx;
        bit sy;
        bit sz;
        for (int k = 0; k < 8; k++)
        begin
            sx = (k == 1 || k == 2 || k == 5 || k == 6);
            sy = (k == 2 || k == 3 || k == 6 || k == 7);
            sz = (k >= 4);
            p[0] = clamp32((sx ? -half_ext[0] : half_ext[0]) + offs[0]);
            p[1] = clamp32((sy ? -half_ext[1] : half_ext[1]) + offs[1]);
            p[2] = clamp32((sz ? -half_ext[2] : half_ext[2]) + offs[2]);
            for (int r = 0; r < 3; r++)
            begin
                corner[3*k+r] = clamp32(qmul(lin[r], p[0]) + qmul(lin[3+r], p[1])
                                        + qmul(lin[6+r], p[2]));
            end
        end
        for (int f = 0; f < 6; f++)
        begin
            face_normal(f);
            dot = 0;
            for (int i = 0; i < 3; i++)
            begin
                dot += qmul(corner[3*PLANE_PT[f]+i], nrm[3*f+i]);
            end
            e.idx  = f[2:0];
            e.x    = nrm[3*f][31:0];
            e.y    = nrm[3*f+1][31:0];
            e.z    = nrm[3*f+2][31:0];
            t      = clamp32(-(dot + radius));
            e.w    = t[31:0];
            e.last = 1'b0;
            plane_q.insert(plane_q.size(), e);
        end
        // bound of translated corners, grown by the radius on both sides
        for (int k = 0; k < 8; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t = clamp32(corner[3*k+i] + trans[i]);
                if (k == 0 || t - radius < lo[i])
                begin
                    lo[i] = t - radius;
                end
                if (k == 0 || t + radius > hi[i])
                begin
                    hi[i] = t + radius;
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            lo[i] = clamp32(lo[i]);
            hi[i] = clamp32(hi[i]);
        end
        e.idx  = IDX_LO;
        e.x    = lo[0][31:0];
        e.y    = lo[1][31:0];
        e.z    = lo[2][31:0];
        e.w    = '0;
        e.last = 1'b0;
        plane_q.insert(plane_q.size(), e);
        e.idx  = IDX_HI;
        e.x    = hi[0][31:0];
        e.y    = hi[1][31:0];
        e.z    = hi[2][31:0];
        e.w    = '0;
        e.last = 1'b1;
        plane_q.insert(plane_q.size(), e);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        box_word_t e;
        longint v[3];
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                lin[i] = 0;
            end
            for (int i = 0; i < 3; i++)
            begin
                trans[i] = 0;
                half_ext[i] = 0;
                offs[i] = 0;
            end
            radius = 0;
            errors = 0;
            plane_q.delete();
            pending = 0;
        end
        else
        begin
            // result words first: they came from earlier boxes
            if (result_strobe)
            begin
                if (plane_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected result word idx=%0d", item_index);
                    end
                end
                else
                begin
                    e = plane_q.pop_front();
                    if (e.idx !== item_index || e.x !== comp_x || e.y !== comp_y
                        || e.z !== comp_z || e.w !== comp_w || e.last !== last_item)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("word mismatch exp idx=%0d %h %h %h %h last=%b",
                                     e.idx, e.x, e.y, e.z, e.w, e.last);
                            $display("               got idx=%0d %h %h %h %h last=%b",
                                     item_index, comp_x, comp_y, comp_z, comp_w,
                                     last_item);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                radius = longint'(cfg_data);
            end
            if (start && !busy)
            begin
                v[0] = longint'(val_x);
                v[1] = longint'(val_y);
                v[2] = longint'(val_z);
                for (int i = 0; i < 3; i++)
                begin
                    if (slot <= SLOT_COL2)
                    begin
                        lin[3*slot+i] = v[i];
                    end
                    else if (slot == SLOT_TRANS)
                    begin
                        trans[i] = v[i];
                    end
                    else if (slot == SLOT_SIZE)
                    begin
                        half_ext[i] = v[i] >>> 1;
                    end
                    else if (slot == SLOT_OFFS)
                    begin
                        offs[i] = v[i];
                    end
                end
                if (go)
                begin
                    build_box();
                end
            end
            pending = plane_q.size();
        end
    end

endmodule

// File: bench/oriented_box_plane_builder_tb.sv
// Testbench top for oriented_box_plane_builder: drives load words and radius
// writes, gives the verdict. Depends on obpb_pkg and obpb_checker.
module oriented_box_plane_builder_tb;
    import obpb_pkg::*;

    localparam int WORDS      = 300;
    localparam int IDLE_LIMIT = 20000;  // watchdog limit, far above a whole box build
    localparam int SETTLE     = 1200;   // build latency plus margin

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  slot;
    word_t       val_x;
    word_t       val_y;
    word_t       val_z;
    logic        go;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [30:0] cfg_data;
    logic        result_strobe;
    logic [2:0]  item_index;
    word_t       comp_x;
    word_t       comp_y;
    word_t       comp_z;
    word_t       comp_w;
    logic        last_item;
    int          errors;
    int          pending;

    int words_sent;
    int burst_left;
    int idle_cycles = 0;

    oriented_box_plane_builder uut (.*);

    obpb_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog: any handshake or result word counts as progress
    always @(posedge clk)
    begin
        if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("oriented_box_plane_builder: mismatch");
            $finish;
        end
    end

    // one load word; start stays high across a burst, usually drops for a random gap
    task automatic send_word(input logic [2:0] s, input word_t x, input word_t y,
                             input word_t z, input logic g);
        @(negedge clk);
        slot  <= s;
        val_x <= x;
        val_y <= y;
        val_z <= z;
        go    <= g;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        words_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 10);
            if ($urandom_range(0, 3) != 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end
        end
    endtask

    // hold off until every expected word is out and the block has settled
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_radius(input logic [30:0] r);
        drain();
        cfg_data  <= r;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly a few units in Q16.16, sometimes full range or an extreme
    function automatic word_t pick_val(input bit wide);
        int sel;
        sel = $urandom_range(0, 19);
        if (wide || sel == 0)
        begin
            return $urandom;
        end
        if (sel == 1)
        begin
            return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
        end
        return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endfunction

    // well-formed box: all six slots in shuffled order, go on the last one
    task automatic random_box(input bit wide);
        logic [2:0] order[6];
        logic [2:0] tmp;
        int j;
        for (int i = 0; i < 6; i++)
        begin
            order[i] = i[2:0];
        end
        for (int i = 5; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < 6; i++)
        begin
            send_word(order[i], pick_val(wide), pick_val(wide), pick_val(wide), i == 5);
        end
    endtask

    task automatic noise_word();
        send_word(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                  $urandom_range(0, 5) == 0);
    endtask

    task automatic random_phase(input int n);
        int stop;
        stop = words_sent + n;
        while (words_sent < stop)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                noise_word();
            end
            else
            begin
                random_box($urandom_range(0, 7) == 0);
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        slot       = SLOT_COL0;
        val_x      = '0;
        val_y      = '0;
        val_z      = '0;
        go         = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        words_sent = 0;
        burst_left = 1;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // all-zero state: every face degenerate, zero normals
        send_word(SLOT_COL0, '0, '0, '0, 1'b1);

        // unit cube under identity, size 2.0, offset zero
        send_word(SLOT_COL0, 32'sh00010000, '0, '0, 1'b0);
        send_word(SLOT_COL1, '0, 32'sh00010000, '0, 1'b0);
        send_word(SLOT_COL2, '0, '0, 32'sh00010000, 1'b0);
        send_word(SLOT_TRANS, 32'sh00030000, -32'sh00020000, 32'sh00000001, 1'b0);
        send_word(SLOT_SIZE, 32'sh00020000, 32'sh00020000, 32'sh00020000, 1'b0);
        send_word(SLOT_OFFS, '0, '0, '0, 1'b1);

        // unused slots store nothing but go still builds
        send_word(SLOT_SPARE_A, 32'sh7fffffff, 32'sh80000000, 32'sh12345678, 1'b0);
        send_word(SLOT_SPARE_B, 32'shdeadbeef, 32'sh80000000, 32'sh7fffffff, 1'b1);

        // negative odd size floors on halving; flat box in z
        send_word(SLOT_SIZE, -32'sh00030001, 32'sh00000003, '0, 1'b1);

        // extremes everywhere: saturating corners and sums
        send_word(SLOT_COL0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
        send_word(SLOT_COL1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0);
        send_word(SLOT_COL2, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0);
        send_word(SLOT_TRANS, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
        send_word(SLOT_SIZE, 32'sh80000001, 32'sh7fffffff, 32'sh80000000, 1'b0);
        send_word(SLOT_OFFS, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b1);

        // sender waits for every word before going on
        drain();
        random_phase(60);

        write_radius(31'h7fffffff);
        send_word(SLOT_TRANS, 32'sh7fffffff, 32'sh80000000, '0, 1'b1);
        random_phase(60);

        write_radius(31'h00010000);
        random_phase(60);

        write_radius(31'($urandom_range(0, 32'h000fffff)));
        random_phase(60);

        write_radius(31'($urandom));
        random_phase(WORDS - words_sent);

        write_radius('0);
        random_phase(6);

        drain();
        if (errors == 0 && pending == 0)
        begin
            $display("oriented_box_plane_builder: match");
        end
        else
        begin
            $display("oriented_box_plane_builder: mismatch");
        end
        $finish;
    end

endmodule
